>>> src/sample_dma_buffer_cache_unit_defines.svh
// Assertion macros used by the sample buffer cache RTL
`ifndef SAMPLE_DMA_BUFFER_CACHE_UNIT_DEFINES_SVH
`define SAMPLE_DMA_BUFFER_CACHE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SDBC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdbc assertion failed");
`define SDBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdbc assertion failed");
`else
`define SDBC_ASSERT_IMPL(lbl, ante, cons)
`define SDBC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/sdbc_pkg.sv
// Types and constants of the sample buffer cache
package sdbc_pkg;
	localparam int SLOT_COUNT = 80;
	localparam int BUFFER_BYTES = 1024;
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int SLOT_W = 7;
	localparam int BOFF_W = 10;
	localparam int ADDR_W = 31;
	localparam int LEN_W = 12;
	localparam int FRAME_W = 32;

	typedef enum logic [1:0] {
		ST_HIT = 2'd0,
		ST_MISS = 2'd1,
		ST_NOSLOT = 2'd2
	} status_t;

	typedef struct packed {
		logic kind;
		logic [ADDR_W-1:0] rom_offset;
		logic [LEN_W-1:0] length;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic [SLOT_W-1:0] slot;
		logic [BOFF_W-1:0] buffer_offset;
		logic [ADDR_W-1:0] fetch_address;
	} out_item_t;
endpackage

>>> src/sdbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
module sdbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/sample_dma_buffer_cache_unit.sv
// Sample buffer cache: a sequencer over four synchronous RAMs (slot starts, last-use
// frames, ordered used list, free list). One item is worked at a time. A fetch request
// scans the used list slot by slot (read the entry, select its slot, compare); a miss
// then closes the free list up and opens a gap in the used list, with a read and a
// write per entry moved. A frame-begin item checks every used slot and returns each
// stale one to the free list, moving the free entries up for each evicted slot.
// After reset the block loads the free list before it takes the first item.
// A result waits in an output register, and the next item is taken meanwhile.
`include "sample_dma_buffer_cache_unit_defines.svh"
module sample_dma_buffer_cache_unit
	import sdbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	typedef enum logic [18:0] {
		S_CLR    = 19'h00001,
		S_IDLE   = 19'h00002,
		S_SC_RD  = 19'h00004,
		S_SC_SL  = 19'h00008,
		S_SC_CMP = 19'h00010,
		S_MISS   = 19'h00020,
		S_NS_OUT = 19'h00040,
		S_FR_TAK = 19'h00080,
		S_FSH_RD = 19'h00100,
		S_FSH_WR = 19'h00200,
		S_USH_RD = 19'h00400,
		S_USH_WR = 19'h00800,
		S_INS    = 19'h01000,
		S_FB_RD  = 19'h02000,
		S_FB_SL  = 19'h04000,
		S_FB_CMP = 19'h08000,
		S_FI_RD  = 19'h10000,
		S_FI_WR  = 19'h20000,
		S_OUT    = 19'h40000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] p_q, i_q, j_q, kept_q, clr_q;
	logic [CNT_W-1:0] used_cnt_q, free_cnt_q;
	logic [FRAME_W-1:0] frame_q;
	logic [IDX_W-1:0] s_q;
	logic [ADDR_W-1:0] off_q;
	logic [ADDR_W:0] end_q;
	out_item_t res_q, out_q;
	logic out_valid_q;
	logic out_load;

	// RAM ports
	logic st_we, lf_we, us_we, fr_we;
	logic [IDX_W-1:0] st_wa, lf_wa, us_wa, fr_wa;
	logic [IDX_W-1:0] st_ra, lf_ra, us_ra, fr_ra;
	logic [ADDR_W-1:0] st_wd, st_rd;
	logic [FRAME_W-1:0] lf_wd, lf_rd;
	logic [IDX_W-1:0] us_wd, us_rd, fr_wd, fr_rd;

	sdbc_ram #(.WIDTH(ADDR_W), .DEPTH(SLOT_COUNT)) u_start (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
	sdbc_ram #(.WIDTH(FRAME_W), .DEPTH(SLOT_COUNT)) u_last (
		.clk(clk), .we(lf_we), .waddr(lf_wa), .wdata(lf_wd), .raddr(lf_ra), .rdata(lf_rd));
	sdbc_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_used (
		.clk(clk), .we(us_we), .waddr(us_wa), .wdata(us_wd), .raddr(us_ra), .rdata(us_rd));
	sdbc_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

	logic [ADDR_W:0] lim;
	logic no_room, hit, stale;
	logic [ADDR_W-1:0] new_start;

	assign lim = {1'b0, st_rd} + (ADDR_W+1)'(BUFFER_BYTES);
	assign hit = end_q <= lim;
	assign no_room = (free_cnt_q == '0) || (used_cnt_q >= CNT_W'(SLOT_COUNT));
	assign stale = (lf_rd + FRAME_W'(1)) < frame_q;
	assign new_start = {off_q[ADDR_W-1:1], 1'b0};
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		st_we = 1'b0; st_wa = s_q; st_wd = new_start; st_ra = us_rd;
		lf_we = 1'b0; lf_wa = s_q; lf_wd = frame_q; lf_ra = us_rd;
		us_we = 1'b0; us_wa = p_q[IDX_W-1:0]; us_wd = s_q; us_ra = p_q[IDX_W-1:0];
		fr_we = 1'b0; fr_wa = '0; fr_wd = s_q; fr_ra = '0;
		case (state_q)
			S_CLR: begin
				fr_we = 1'b1;
				fr_wa = clr_q[IDX_W-1:0];
				fr_wd = clr_q[IDX_W-1:0];
			end
			S_SC_CMP: begin
				lf_we = (st_rd <= off_q) && hit;
			end
			S_MISS: begin
				us_ra = '0;
				fr_ra = '0;
			end
			S_FSH_RD: fr_ra = i_q[IDX_W-1:0];
			S_FSH_WR: begin
				fr_we = 1'b1;
				fr_wa = IDX_W'(i_q - CNT_W'(1));
				fr_wd = fr_rd;
			end
			S_USH_RD: us_ra = IDX_W'(i_q - CNT_W'(1));
			S_USH_WR: begin
				us_we = 1'b1;
				us_wa = i_q[IDX_W-1:0];
				us_wd = us_rd;
			end
			S_INS: begin
				us_we = 1'b1;
				st_we = 1'b1;
				lf_we = 1'b1;
			end
			S_FB_RD: us_ra = i_q[IDX_W-1:0];
			S_FB_CMP: begin
				if (stale) begin
					fr_we = (free_cnt_q == '0);
				end else begin
					us_we = 1'b1;
					us_wa = kept_q[IDX_W-1:0];
				end
			end
			S_FI_RD: begin
				fr_ra = IDX_W'(j_q - CNT_W'(1));
				if (j_q <= CNT_W'(1)) begin
					fr_we = 1'b1;
					fr_wa = IDX_W'(1);
				end
			end
			S_FI_WR: begin
				fr_we = 1'b1;
				fr_wa = j_q[IDX_W-1:0];
				fr_wd = fr_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			used_cnt_q <= '0;
			free_cnt_q <= CNT_W'(SLOT_COUNT);
			frame_q <= '0;
			out_valid_q <= 1'b0;
			p_q <= '0; i_q <= '0; j_q <= '0; kept_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CNT_W'(1);
					if (clr_q == CNT_W'(SLOT_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						off_q <= in_item.rom_offset;
						end_q <= {1'b0, in_item.rom_offset} + (ADDR_W+1)'(in_item.length);
						p_q <= '0; i_q <= '0; kept_q <= '0;
						state_q <= in_item.kind ? S_FB_RD : S_SC_RD;
					end
				end
				S_SC_RD: state_q <= (p_q < used_cnt_q) ? S_SC_SL : S_MISS;
				S_SC_SL: begin
					s_q <= us_rd;
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					if (st_rd > off_q) begin
						state_q <= S_MISS;
					end else if (hit) begin
						res_q <= '{ST_HIT, SLOT_W'(s_q), BOFF_W'(off_q - st_rd), '0};
						state_q <= S_OUT;
					end else begin
						p_q <= p_q + CNT_W'(1);
						state_q <= S_SC_RD;
					end
				end
				S_MISS: begin
					i_q <= CNT_W'(1);
					state_q <= no_room ? S_NS_OUT : S_FR_TAK;
				end
				S_NS_OUT: begin
					res_q <= '{ST_NOSLOT,
						(used_cnt_q != '0) ? SLOT_W'(us_rd) : '0, '0, '0};
					state_q <= S_OUT;
				end
				S_FR_TAK: begin
					s_q <= fr_rd;
					state_q <= S_FSH_RD;
				end
				S_FSH_RD: begin
					if (i_q < free_cnt_q) begin
						state_q <= S_FSH_WR;
					end else begin
						free_cnt_q <= free_cnt_q - CNT_W'(1);
						i_q <= used_cnt_q;
						state_q <= S_USH_RD;
					end
				end
				S_FSH_WR: begin
					i_q <= i_q + CNT_W'(1);
					state_q <= S_FSH_RD;
				end
				S_USH_RD: state_q <= (i_q > p_q) ? S_USH_WR : S_INS;
				S_USH_WR: begin
					i_q <= i_q - CNT_W'(1);
					state_q <= S_USH_RD;
				end
				S_INS: begin
					used_cnt_q <= used_cnt_q + CNT_W'(1);
					res_q <= '{ST_MISS, SLOT_W'(s_q), BOFF_W'(off_q[0]), new_start};
					state_q <= S_OUT;
				end
				S_FB_RD: begin
					if (i_q < used_cnt_q) begin
						state_q <= S_FB_SL;
					end else begin
						used_cnt_q <= kept_q;
						frame_q <= frame_q + FRAME_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_FB_SL: begin
					s_q <= us_rd;
					state_q <= S_FB_CMP;
				end
				S_FB_CMP: begin
					if (stale && free_cnt_q != '0 && free_cnt_q < CNT_W'(SLOT_COUNT)) begin
						j_q <= free_cnt_q;
						state_q <= S_FI_RD;
					end else begin
						// evict into an empty free list, drop on a full one, else keep
						if (!stale) begin
							kept_q <= kept_q + CNT_W'(1);
						end else if (free_cnt_q == '0) begin
							free_cnt_q <= CNT_W'(1);
						end
						i_q <= i_q + CNT_W'(1);
						state_q <= S_FB_RD;
					end
				end
				S_FI_RD: begin
					if (j_q > CNT_W'(1)) begin
						state_q <= S_FI_WR;
					end else begin
						free_cnt_q <= free_cnt_q + CNT_W'(1);
						i_q <= i_q + CNT_W'(1);
						state_q <= S_FB_RD;
					end
				end
				S_FI_WR: begin
					j_q <= j_q - CNT_W'(1);
					state_q <= S_FI_RD;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`SDBC_ASSERT_IMPL(a_counts_sum, state_q == S_IDLE, ({1'b0, used_cnt_q} + {1'b0, free_cnt_q}) == (CNT_W+1)'(SLOT_COUNT))
	`SDBC_ASSERT_IMPL(a_hit_no_fetch, out_valid && out_item.status == ST_HIT, out_item.fetch_address == '0)
	`SDBC_ASSERT_IMPL(a_status_code, out_valid, out_item.status == ST_HIT || out_item.status == ST_MISS || out_item.status == ST_NOSLOT)
	`SDBC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
endmodule
